@@ rtl/core/md4_pkg.sv @@
package md4_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } msg_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        digest_last;
  } digest_t;

  typedef logic [3:0][31:0] word4_t;

  typedef struct packed {
    logic       load;
    logic       en;
    logic [5:0] step;
  } rnd_ctl_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hEFCDAB89;
  localparam logic [31:0] INIT_C = 32'h98BADCFE;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] K_ROUND1 = 32'h00000000;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LAST_STEP = 6'd47;

  // Message word used by a given step.
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] idx;
    j = step[3:0];
    case (step[5:4])
      2'd0: idx = j;
      2'd1: idx = {j[1:0], j[3:2]};
      default: idx = {j[0], j[1], j[2], j[3]};
    endcase
    return idx;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [5:0] step);
    logic [4:0] s;
    case ({step[5:4], step[1:0]})
      4'b00_00: s = 5'd3;
      4'b00_01: s = 5'd7;
      4'b00_10: s = 5'd11;
      4'b00_11: s = 5'd19;
      4'b01_00: s = 5'd3;
      4'b01_01: s = 5'd5;
      4'b01_10: s = 5'd9;
      4'b01_11: s = 5'd13;
      4'b10_00: s = 5'd3;
      4'b10_01: s = 5'd9;
      4'b10_10: s = 5'd11;
      4'b10_11: s = 5'd15;
      default:  s = 5'd3;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

@@ rtl/core/md4_message_digest.sv @@
// MD4 message digest, one message byte per request.
//
// Input channel msg / msg_valid / msg_stall: each request carries data_byte,
// byte_valid and last. A request with byte_valid writes one byte; a request
// with last closes the message, pads it and produces the digest. A request
// with neither flag is taken and dropped.
// Output channel digest / digest_valid / digest_stall: four requests per
// message, words A, B, C, D with word_index 0..3, digest_last on D.
//
// Sequence: while idle, msg_stall is low and each byte is taken as offered.
// The 64th byte of a block starts the compression: a load step, 48 round
// steps on the one shared round unit (one message word read from the block
// RAM per step) and a fold step. A last request writes the pad and length
// words and adds one compression, or two compressions when 56 or more bytes
// of the block are used, then loads the four digest words in turn into the
// output register.
// Reset clears the byte count, sets the chaining words to the MD4 initial
// values and empties the output register. The block RAM needs no clearing.
// A stalled digest word holds in the output register; the remaining words
// wait behind it, and msg_stall stays high until the last word is loaded.
module md4_message_digest (
  input  logic             clk,
  input  logic             rst,
  input  md4_pkg::msg_t    msg,
  input  logic             msg_valid,
  output logic             msg_stall,
  output md4_pkg::digest_t digest,
  output logic             digest_valid,
  input  logic             digest_stall
);
  import md4_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_PADZ  = 3'd2;
  localparam logic [2:0] S_START = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_FOLD  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]  state;
  logic [2:0]  resume;
  logic [60:0] byte_total;
  logic [23:0] part;
  logic [3:0]  wcnt;
  logic        len_here;
  logic [5:0]  step;
  logic [1:0]  ocnt;
  logic [31:0] chain [4];

  logic        take;
  logic [5:0]  pos;
  logic [63:0] bitlen;
  logic [31:0] pad_word;
  logic        len_now;
  logic        wen;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  logic [3:0]  raddr;
  logic [31:0] rdata;
  rnd_ctl_t    rctl;
  word4_t      chain_p;
  word4_t      r;
  logic        out_load;

  assign msg_stall = (state != S_IDLE);
  assign take      = msg_valid && !msg_stall;
  assign pos       = byte_total[5:0];
  assign bitlen    = {byte_total, 3'b000};
  // Room for the length in this block when fewer than 56 bytes are used.
  assign len_now   = !(&pos[5:3]);
  assign out_load  = (state == S_OUT) && (!digest_valid || !digest_stall);

  // Head word of the padding: stored bytes, then 0x80, then zeros.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 3 && 2'(i) < pos[1:0]) begin
        pad_word[8*i +: 8] = part[8*i +: 8];
      end else if (2'(i) == pos[1:0]) begin
        pad_word[8*i +: 8] = PAD_BYTE;
      end else begin
        pad_word[8*i +: 8] = 8'h00;
      end
    end
  end

  // Block RAM write port.
  always_comb begin
    wen   = 1'b0;
    waddr = wcnt;
    wdata = 32'h0;
    case (state)
      S_IDLE: begin
        wen   = take && msg.byte_valid && (pos[1:0] == 2'd3);
        waddr = pos[5:2];
        wdata = {msg.data_byte, part};
      end
      S_PAD: begin
        wen   = 1'b1;
        waddr = pos[5:2];
        wdata = pad_word;
      end
      S_PADZ: begin
        wen   = 1'b1;
        waddr = wcnt;
        if (len_here && wcnt == 4'd14) begin
          wdata = bitlen[31:0];
        end else if (len_here && wcnt == 4'd15) begin
          wdata = bitlen[63:32];
        end else begin
          wdata = 32'h0;
        end
      end
      default: begin
        wen = 1'b0;
      end
    endcase
  end

  // Read one step ahead so the word is in rdata when the step runs.
  always_comb begin
    case (state)
      S_ROUND: raddr = msg_index(step + 6'd1);
      default: raddr = msg_index(6'd0);
    endcase
  end

  md4_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_block (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rctl.load = (state == S_START);
  assign rctl.en   = (state == S_ROUND);
  assign rctl.step = step;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      chain_p[i] = chain[i];
    end
  end

  md4_round u_round (
    .clk   (clk),
    .ctl   (rctl),
    .chain (chain_p),
    .w     (rdata),
    .r     (r)
  );

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      resume     <= S_IDLE;
      byte_total <= '0;
      wcnt       <= '0;
      len_here   <= 1'b0;
      step       <= '0;
      ocnt       <= '0;
      chain[0]   <= INIT_A;
      chain[1]   <= INIT_B;
      chain[2]   <= INIT_C;
      chain[3]   <= INIT_D;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            if (msg.byte_valid) begin
              if (pos[1:0] != 2'd3) begin
                part[8*pos[1:0] +: 8] <= msg.data_byte;
              end
              byte_total <= byte_total + 61'd1;
              if (pos == 6'd63) begin
                state  <= S_START;
                resume <= msg.last ? S_PAD : S_IDLE;
              end else if (msg.last) begin
                state <= S_PAD;
              end
            end else if (msg.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          wcnt <= pos[5:2] + 4'd1;
          if (pos[5:2] == 4'd15) begin
            // Head fills the block: compress, then a length-only block.
            state    <= S_START;
            resume   <= S_PADZ;
            len_here <= 1'b1;
          end else begin
            len_here <= len_now;
            state    <= S_PADZ;
          end
        end
        S_PADZ: begin
          wcnt <= wcnt + 4'd1;
          if (wcnt == 4'd15) begin
            state <= S_START;
            if (len_here) begin
              resume <= S_OUT;
            end else begin
              resume   <= S_PADZ;
              len_here <= 1'b1;
            end
          end
        end
        S_START: begin
          step  <= '0;
          state <= S_ROUND;
        end
        S_ROUND: begin
          step <= step + 6'd1;
          if (step == LAST_STEP) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          for (int i = 0; i < 4; i++) begin
            chain[i] <= chain[i] + r[i];
          end
          state <= resume;
        end
        S_OUT: begin
          if (out_load) begin
            ocnt <= ocnt + 2'd1;
            if (ocnt == 2'd3) begin
              chain[0]   <= INIT_A;
              chain[1]   <= INIT_B;
              chain[2]   <= INIT_C;
              chain[3]   <= INIT_D;
              byte_total <= '0;
              state      <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      digest_valid <= 1'b0;
    end else if (out_load) begin
      digest_valid <= 1'b1;
    end else if (!digest_stall) begin
      digest_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest.digest_word <= chain[ocnt];
      digest.word_index  <= ocnt;
      digest.digest_last <= (ocnt == 2'd3);
    end
  end

  a_full_block_starts: assert property (@(posedge clk) disable iff (rst)
    take && msg.byte_valid && pos == 6'd63 |=> state == S_START)
    else $error("full block did not start compression");

  a_rounds_end: assert property (@(posedge clk) disable iff (rst)
    state == S_ROUND && step == LAST_STEP |=> state == S_FOLD)
    else $error("round sequence did not end after the last step");

  a_no_write_in_compress: assert property (@(posedge clk) disable iff (rst)
    wen |-> (state == S_IDLE || state == S_PAD || state == S_PADZ))
    else $error("block write during compression");

  a_digest_order: assert property (@(posedge clk) disable iff (rst)
    out_load && ocnt != 2'd0 |-> digest_valid || $past(digest_valid))
    else $error("digest word loaded out of order");

endmodule

@@ rtl/core/md4_ram.sv @@
module md4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wen,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/md4_round.sv @@
module md4_round (
  input  logic              clk,
  input  md4_pkg::rnd_ctl_t ctl,
  input  md4_pkg::word4_t   chain,
  input  logic [31:0]       w,
  output md4_pkg::word4_t   r
);
  import md4_pkg::*;

  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] sum;
  logic [31:0] t;

  // Round function and constant for this step.
  always_comb begin
    case (ctl.step[5:4])
      2'd0: begin
        f = (r[1] & r[2]) | (~r[1] & r[3]);
        k = K_ROUND1;
      end
      2'd1: begin
        f = (r[1] & r[2]) | (r[1] & r[3]) | (r[2] & r[3]);
        k = K_ROUND2;
      end
      default: begin
        f = r[1] ^ r[2] ^ r[3];
        k = K_ROUND3;
      end
    endcase
    sum = r[0] + f + w + k;
    t   = rotl32(sum, shift_amt(ctl.step));
  end

  // Rotate roles: A takes D, D takes C, C takes B, B takes the new word.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      r <= chain;
    end else if (ctl.en) begin
      r[0] <= r[3];
      r[3] <= r[2];
      r[2] <= r[1];
      r[1] <= t;
    end
  end

endmodule

@@ test/md4_message_digest_tb.sv @@
`timescale 1ns / 100ps

module md4_message_digest_tb;

  import md4_pkg::*;

  // Clock, reset and the two channels of the block.
  logic    clk = 1'b0;
  logic    rst = 1'b1;
  msg_t    msg = '0;
  logic    msg_valid = 1'b0;
  logic    msg_stall;
  digest_t digest;
  logic    digest_valid;
  logic    digest_stall = 1'b0;

  // Shadow state of the hash: chaining words, block buffer, byte count.
  logic [31:0] chain_word [4];
  logic [7:0]  block_bytes [64];
  logic [60:0] byte_count;

  // Digest words that are owed by the block, oldest first.
  digest_t owed_words [$];

  int mismatches = 0;
  int msg_items = 0;     // requests that carry a byte or close a message
  int messages_done = 0;

  // Receiver controls: a one-shot long hold-off and a quiet phase at the end.
  int hold_req = 0;
  int hold_left = 0;
  int burst_left = 0;
  bit quiet_tail = 1'b0;

  md4_message_digest u_top (
    .clk          (clk),
    .rst          (rst),
    .msg          (msg),
    .msg_valid    (msg_valid),
    .msg_stall    (msg_stall),
    .digest       (digest),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Hash predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int s);
    return (v << s) | (v >> (32 - s));
  endfunction

  // Rotate amount of one of the 48 steps.
  function automatic int step_rotate(input int rnd, input int j);
    case (rnd)
      0: case (j % 4) 0: return 3; 1: return 7; 2: return 11; default: return 19; endcase
      1: case (j % 4) 0: return 3; 1: return 5; 2: return 9;  default: return 13; endcase
      default:
         case (j % 4) 0: return 3; 1: return 9; 2: return 11; default: return 15; endcase
    endcase
  endfunction

  function automatic void reset_chain();
    chain_word[0] = INIT_A;
    chain_word[1] = INIT_B;
    chain_word[2] = INIT_C;
    chain_word[3] = INIT_D;
    byte_count = '0;
  endfunction

  // Run the 48-step transform over the buffer and fold it into the chain.
  function automatic void compress_buffer();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, k, t;
    logic [3:0]  j, widx;
    int          rnd;
    for (int i = 0; i < 16; i++) begin
      w[i] = {block_bytes[4*i+3], block_bytes[4*i+2], block_bytes[4*i+1], block_bytes[4*i]};
    end
    a = chain_word[0];
    b = chain_word[1];
    c = chain_word[2];
    d = chain_word[3];
    for (int i = 0; i < 48; i++) begin
      rnd = i / 16;
      j   = 4'(i % 16);
      if (rnd == 0) begin
        f    = (b & c) | (~b & d);
        k    = K_ROUND1;
        widx = j;
      end else if (rnd == 1) begin
        f    = (b & c) | (b & d) | (c & d);
        k    = K_ROUND2;
        widx = {j[1:0], j[3:2]};
      end else begin
        f    = b ^ c ^ d;
        k    = K_ROUND3;
        widx = {j[0], j[1], j[2], j[3]};
      end
      t = rotate_left(a + f + w[widx] + k, step_rotate(rnd, int'(j)));
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain_word[0] += a;
    chain_word[1] += b;
    chain_word[2] += c;
    chain_word[3] += d;
  endfunction

  // Apply one accepted request to the shadow state; queue the digest on last.
  function automatic void absorb_request(input msg_t m);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    digest_t     word;
    if (m.byte_valid) begin
      pos = byte_count[5:0];
      block_bytes[pos] = m.data_byte;
      byte_count = byte_count + 61'd1;
      if (pos == 6'd63) compress_buffer();
    end
    if (m.last) begin
      pos = byte_count[5:0];
      block_bytes[pos] = PAD_BYTE;
      for (int i = int'(pos) + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room left for the length: flush this block and pad a fresh one.
      if (pos >= 6'd56) begin
        compress_buffer();
        for (int i = 0; i < 64; i++) block_bytes[i] = 8'h00;
      end
      bit_len = {byte_count, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[8*i +: 8];
      compress_buffer();
      for (int i = 0; i < 4; i++) begin
        word.digest_word = chain_word[i];
        word.word_index  = 2'(i);
        word.digest_last = (i == 3);
        owed_words.push_back(word);
      end
      reset_chain();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one request, wait for it to be taken, then predict.
  // ---------------------------------------------------------------------------

  task automatic send_request(input logic [7:0] data, input logic has_byte,
                              input logic is_last);
    msg_t m;
    // Drop valid for a random burst now and then, unless in the quiet tail.
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      msg_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    m.data_byte  = data;
    m.byte_valid = has_byte;
    m.last       = is_last;
    msg       <= m;
    msg_valid <= 1'b1;
    // Hold the request until a rising edge sees the stall low.
    do @(posedge clk); while (msg_stall);
    absorb_request(m);
    if (has_byte || is_last) msg_items++;
    if (is_last) messages_done++;
    @(negedge clk);
  endtask

  // One whole message of random bytes; the last flag either rides on the
  // final byte or comes as an empty request of its own. Idle requests are
  // scattered in between.
  task automatic send_message(input int len);
    bit close_on_byte;
    close_on_byte = (len > 0) && $urandom_range(0, 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) send_request(8'($urandom), 1'b0, 1'b0);
      send_request(8'($urandom), 1'b1, close_on_byte && (i == len - 1));
    end
    if (!close_on_byte) send_request(8'($urandom), 1'b0, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, a long hold-off on request, none at the end.
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      digest_stall <= 1'b1;
    end else if (quiet_tail) begin
      digest_stall <= 1'b0;
    end else if (burst_left != 0) begin
      burst_left--;
      digest_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      burst_left = $urandom_range(0, 7);
      digest_stall <= 1'b1;
    end else begin
      digest_stall <= 1'b0;
    end
  end

  // Compare every accepted digest word with the oldest one owed.
  always @(posedge clk) begin
    digest_t want;
    if (!rst && digest_valid && !digest_stall) begin
      if (owed_words.size() == 0) begin
        $error("unexpected digest word %h index %0d", digest.digest_word, digest.word_index);
        mismatches++;
      end else begin
        want = owed_words.pop_front();
        if (digest.digest_word !== want.digest_word) begin
          $error("digest_word: expected %h, got %h", want.digest_word, digest.digest_word);
          mismatches++;
        end
        if (digest.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, digest.word_index);
          mismatches++;
        end
        if (digest.digest_last !== want.digest_last) begin
          $error("digest_last: expected %0b, got %0b", want.digest_last, digest.digest_last);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty message first, idle requests, byte extremes, last with and without
  // a byte, and the short well-known message "abc".
  task automatic test_directed();
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    send_request(8'hA5, 1'b1, 1'b0);
    send_request(8'h5A, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
  endtask

  // Hold the receiver off long enough that the block backs up into its input.
  task automatic test_backpressure();
    @(posedge clk);
    hold_req = 400;
    @(negedge clk);
    for (int n = 0; n < 3; n++) send_message($urandom_range(1, 5));
  endtask

  // Mostly short messages; some land on the block and padding edges.
  task automatic test_random_messages();
    int len;
    while (msg_items < 110 || messages_done < 12) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(0, 12);
      end
      send_message(len);
    end
  endtask

  // Finish with no idling on either side.
  task automatic test_quiet_tail();
    @(posedge clk);
    wait (hold_left == 0);
    quiet_tail = 1'b1;
    @(negedge clk);
    send_message(3);
    send_message(0);
    send_message(64);
    send_message(7);
  endtask

  initial begin
    reset_chain();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_backpressure();
    test_random_messages();
    test_quiet_tail();
    msg_valid <= 1'b0;

    // Drain what is still owed, then let the pipeline settle.
    while (owed_words.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    if (mismatches == 0 && owed_words.size() == 0) begin
      $display("md4_message_digest: match");
    end else begin
      $display("md4_message_digest: mismatch");
    end
    $finish;
  end

  // Watchdog, well past the slowest correct run.
  initial begin
    #5000000;
    $display("md4_message_digest: mismatch");
    $finish;
  end

endmodule
